/* rtl/fed_pkg.sv */
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types and constants of the feedback echo delay block.
// ----------------------------------------------------------------------------
package fed_pkg;

   // sample and register widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CSR_W    = 11;

   // delay register reset value, 20 ms at 44.1 kHz
   localparam logic [CSR_W-1:0] DELAY_RESET = 11'd882;

   // fill count saturates here
   localparam logic [CSR_W-1:0] FILL_MAX = 11'h7FF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // halve a sample, truncating toward zero
   function automatic sample_type half_toward_zero(input sample_type value);
      sample_type biased;
      biased = value + sample_type'({{(SAMPLE_W-1){1'b0}}, value[SAMPLE_W-1]});
      return biased >>> 1;
   endfunction

endpackage

/* rtl/feedback_echo_delay.sv */
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Feedback comb filter that adds an echo to a stream of 16-bit audio samples.
// ----------------------------------------------------------------------------
// One sample enters per clock and one processed sample leaves per clock
// unless the receiver stalls; each sample passes through the input stage
// and the result register. The rate is set by the delay RAM, which takes one
// read (the output from D samples back) and one write (the new output) per
// sample; for a delay of one sample the previous output is forwarded around
// the RAM. Output is y = x + y[n-D]/2 (halved toward zero, sum wrapped to 16
// bits) once the current buffer holds at least D samples, else y = x. A
// sample with tlast set ends the buffer; the next one starts without echo.
// Write the delay register through csr_we/csr_wdata only while the block is
// idle; the block does not enforce this. 0 acts as 1 and values above
// MAX_DELAY act as MAX_DELAY. The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
   parameter int unsigned MAX_DELAY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,    // delay_samples
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] sample_in
   input  logic        req_tlast,    // last_in
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] sample_out
   output logic        rsp_tlast     // last_out
);

   localparam int unsigned PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int unsigned DLY_W = $clog2(MAX_DELAY + 1);
   localparam int unsigned CMP_W = (DLY_W > fed_pkg::CSR_W) ? DLY_W : fed_pkg::CSR_W;
   localparam logic [CMP_W-1:0] MAX_D = CMP_W'(MAX_DELAY);
   localparam logic [CMP_W-1:0] ONE_D = CMP_W'(1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_DELAY - 1);

   // control and buffer state
   logic [fed_pkg::CSR_W-1:0] delay_ff;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [fed_pkg::CSR_W-1:0] fill_ff, fill_in;

   // input stage
   logic                 s1_valid_ff;
   fed_pkg::sample_type  s1_sample_ff;
   logic                 s1_last_ff;
   logic                 s1_echo_ff;
   logic                 s1_fwd_ff;
   fed_pkg::sample_type  s1_fwd_data_ff;
   logic [PTR_W-1:0]     s1_addr_ff;

   // result stage
   logic                 rsp_valid_ff;
   fed_pkg::sample_type  rsp_sample_ff;
   logic                 rsp_last_ff;

   logic                 req_acc;
   logic                 s1_adv;
   logic [CMP_W-1:0]     dly_ext;
   logic [CMP_W-1:0]     eff_delay;
   logic [CMP_W-1:0]     ptr_ext;
   logic [PTR_W-1:0]     rd_addr;
   logic                 echo_on;
   logic                 fwd_hit;
   logic [15:0]          ram_rdata;
   fed_pkg::sample_type  past;
   fed_pkg::sample_type  y;

   // handshakes
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   // delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= fed_pkg::DELAY_RESET;
      end else if (csr_we) begin
         delay_ff <= csr_wdata;
      end
   end

   // clamp delay to 1..MAX_DELAY
   always_comb begin
      dly_ext = CMP_W'(delay_ff);
      priority if (dly_ext == '0) begin
         eff_delay = ONE_D;
      end else if (dly_ext > MAX_D) begin
         eff_delay = MAX_D;
      end else begin
         eff_delay = dly_ext;
      end
   end

   // read address: ring pointer minus delay, wrapped
   assign ptr_ext = CMP_W'(ptr_ff);
   always_comb begin
      if (ptr_ext >= eff_delay) begin
         rd_addr = PTR_W'(ptr_ext - eff_delay);
      end else begin
         rd_addr = PTR_W'(ptr_ext + MAX_D - eff_delay);
      end
   end

   assign echo_on = CMP_W'(fill_ff) >= eff_delay;
   // previous sample leaves the input stage on this edge, RAM not yet written
   assign fwd_hit = s1_adv && (eff_delay == ONE_D);

   // per accepted transaction: ring pointer steps, fill count steps or clears
   always_comb begin
      ptr_in  = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
      fill_in = fill_ff;
      if (req_tlast) begin
         fill_in = '0;
      end else if (fill_ff != fed_pkg::FILL_MAX) begin
         fill_in = fill_ff + fed_pkg::CSR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
      end else if (req_acc) begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
      end
   end

   // delay memory of past outputs
   fed_ram #(
      .WIDTH (fed_pkg::SAMPLE_W),
      .DEPTH (MAX_DELAY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (y),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // input stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_sample_ff   <= fed_pkg::sample_type'(req_tdata);
         s1_last_ff     <= req_tlast;
         s1_echo_ff     <= echo_on;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= y;
         s1_addr_ff     <= ptr_ff;
      end
   end

   // echo sum
   assign past = s1_fwd_ff ? s1_fwd_data_ff : fed_pkg::sample_type'(ram_rdata);
   always_comb begin
      if (s1_echo_ff) begin
         y = s1_sample_ff + fed_pkg::half_toward_zero(past);
      end else begin
         y = s1_sample_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sample_ff <= y;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // accepted transaction lands in the input stage
   a_req_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted transaction missing from input stage");

   // input stage moving on always presents a response
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("input stage advanced without a response");

   // stalled input stage keeps its sample
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_sample_ff))
      else $error("stalled input stage lost its sample");

   // end of buffer restarts the fill count
   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> fill_ff == '0)
      else $error("fill count not cleared after last sample");

   // forwarding only for a one-sample delay
   a_fwd_delay: assert property (@(posedge clock) disable iff (reset)
      req_acc && fwd_hit |-> eff_delay == ONE_D && s1_valid_ff)
      else $error("forwarding taken for a delay other than one");
`endif

endmodule

/* rtl/fed_ram.sv */
// ----------------------------------------------------------------------------
// fed_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fed_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/feedback_echo_delay_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_tb
// Self-checking bench for the feedback echo delay block. Samples are driven
// as buffers on the request stream while the receiver stalls at random, a
// local model of the echo ring predicts each output, and every response
// transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module feedback_echo_delay_tb;

   localparam int unsigned RING_DEPTH  = 1024;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned QUIET_LIMIT = 2000;
   // reset delay plus the corner samples that land on the echo
   localparam int unsigned ECHO_RUN    = 896;

   // corner samples used in the directed buffers
   localparam fed_pkg::sample_type CORNER_SAMPLES [0:13] = '{
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, -16'sd1, -16'sd1, 16'sd1,
      16'sd1, 16'sd0, -16'sd3, 16'sd3, 16'sh4000, -16'sd16385, 16'sd2
   };

   typedef struct packed {
      fed_pkg::sample_type sample;
      logic                last;
   } echo_item_type;

   // dut connections, all inputs known from time zero
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic [fed_pkg::CSR_W-1:0] csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [15:0]               rsp_tdata;
   logic                      rsp_tlast;

   // stimulus and prediction stores
   echo_item_type             pending_samples[$];
   echo_item_type             expected_outputs[$];
   echo_item_type             next_sample;
   echo_item_type             expected_item;

   // echo model state
   fed_pkg::sample_type       echo_ring [RING_DEPTH];
   logic [9:0]                ring_ptr   = '0;
   logic [fed_pkg::CSR_W-1:0] fill_cnt   = '0;
   logic [fed_pkg::CSR_W-1:0] delay_cfg  = fed_pkg::DELAY_RESET;

   // idle control and bookkeeping
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   logic              hold_req      = 1'b0;
   logic              hold_taken    = 1'b0;
   int unsigned       hold_left     = 0;
   int unsigned       quiet_cycles  = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       sample_count  = 0;
   int unsigned       echo_count    = 0;
   int unsigned       buffer_count  = 0;

   feedback_echo_delay #(.MAX_DELAY(RING_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // next output of the comb filter, advances ring and fill count
   function automatic echo_item_type apply_echo(echo_item_type din);
      echo_item_type dout;
      int unsigned   dly;
      int            past;
      logic [9:0]    rd_addr;
      dly = 32'(delay_cfg);
      if (dly < 1) dly = 1;
      if (dly > RING_DEPTH) dly = RING_DEPTH;
      dout = din;
      if (fill_cnt >= dly) begin
         rd_addr = ring_ptr - 10'(dly);
         past = int'(echo_ring[rd_addr]);
         dout.sample = fed_pkg::sample_type'(int'(din.sample) + past / 2);
         echo_count++;
      end
      echo_ring[ring_ptr] = dout.sample;
      ring_ptr = ring_ptr + 10'd1;
      if (din.last) begin
         fill_cnt = '0;
         buffer_count++;
      end else if (fill_cnt != fed_pkg::FILL_MAX) begin
         fill_cnt = fill_cnt + fed_pkg::CSR_W'(1);
      end
      return dout;
   endfunction

   function automatic fed_pkg::sample_type pick_sample();
      if ($urandom_range(7) == 0)
         return CORNER_SAMPLES[$urandom_range(13)];
      return fed_pkg::sample_type'($urandom);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // queue buffers, most long enough to reach the echo, some short
   task automatic add_buffers(input int unsigned count, input int unsigned dly,
                              input bit open_end);
      int unsigned   left;
      int unsigned   run;
      bit            cut;
      echo_item_type item;
      left = count;
      while (left != 0) begin
         if ($urandom_range(4) == 0)
            run = $urandom_range(dly, 1);
         else
            run = $urandom_range(4 * dly + 8, dly + 1);
         cut = (run >= left);
         if (cut) run = left;
         for (int unsigned i = 0; i < run; i++) begin
            item.sample = pick_sample();
            item.last   = (i == run - 1) && !(cut && open_end);
            pending_samples.push_back(item);
         end
         left -= run;
      end
   endtask

   task automatic add_sample(input fed_pkg::sample_type value, input logic last);
      echo_item_type item;
      item.sample = value;
      item.last   = last;
      pending_samples.push_back(item);
   endtask

   // block is idle once every sample went in and every output came back
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_tvalid || expected_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_delay(input logic [fed_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      delay_cfg <= value;
      @(posedge clock);
   endtask

   task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct <= send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // request driver, predicts on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            next_sample.sample = fed_pkg::sample_type'(req_tdata);
            next_sample.last   = req_tlast;
            expected_outputs.push_back(apply_echo(next_sample));
            sample_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_sample = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_sample.sample;
               req_tlast  <= next_sample.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, sample %0d last %0b",
                                         $signed(rsp_tdata), rsp_tlast));
            end else begin
               expected_item = expected_outputs.pop_front();
               if (rsp_tdata !== expected_item.sample)
                  report_mismatch($sformatf("sample_out got %0d want %0d",
                                            $signed(rsp_tdata), expected_item.sample));
               if (rsp_tlast !== expected_item.last)
                  report_mismatch($sformatf("last_out got %0b want %0b",
                                            rsp_tlast, expected_item.last));
            end
         end
         if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset delay: corner values at the start and again where they echo
      set_idle(29, 81);
      for (int unsigned i = 0; i < ECHO_RUN; i++) begin
         if (i < 14)
            add_sample(CORNER_SAMPLES[i], 1'b0);
         else if (i >= fed_pkg::DELAY_RESET)
            add_sample(CORNER_SAMPLES[i - fed_pkg::DELAY_RESET], i == ECHO_RUN - 1);
         else
            add_sample(pick_sample(), 1'b0);
      end
      wait_drained();

      // short delay, receiver held off to back up the input
      write_delay(11'd7);
      @(posedge clock);
      hold_req <= 1'b1;
      add_buffers(40, 7, 1'b1);
      wait_drained();

      // delay zero acts as one, feedback from the previous output
      set_idle(81, 29);
      write_delay(11'd0);
      foreach (CORNER_SAMPLES[i])
         add_sample(CORNER_SAMPLES[i], i == 13);
      add_sample(16'sh7FFF, 1'b0);
      add_sample(16'sh7FFF, 1'b0);
      add_buffers(20, 1, 1'b1);
      wait_drained();

      // full ring depth and a clamped value, echo must stay off
      write_delay(11'd1024);
      for (int unsigned i = 0; i < 12; i++)
         add_sample(pick_sample(), 1'b0);
      wait_drained();
      write_delay(11'd2047);
      for (int unsigned i = 0; i < 12; i++)
         add_sample(pick_sample(), i == 11);
      wait_drained();

      // ring pointer wraps and echo reads reach back across the wrap
      set_idle(0, 0);
      write_delay(11'd30);
      add_buffers(50, 30, 1'b0);
      wait_drained();

      write_delay(11'd3);
      add_buffers(24, 3, 1'b0);
      wait_drained();
      repeat (10) @(posedge clock);

      $display("run covered %0d samples in %0d closed buffers, %0d with echo added",
               sample_count, buffer_count, echo_count);
      $display("delays 0, 1, 3, 7, 30, 882, 1024 and 2047, with a %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
rtl/fed_pkg.sv
rtl/fed_ram.sv
rtl/feedback_echo_delay.sv
dv/feedback_echo_delay_tb.sv
